// File: hdl/m4i_pkg.sv
// shared constants, operand tables and status type for the 4x4 matrix inverse
`timescale 1ns / 1ps
`default_nettype none
package m4i_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int NUM_PROD  = 24;
	localparam int NUM_TERMS = 6;
	localparam logic [5:0] COF_BASE = 6'd32;

	// two store indices per pairwise product
	localparam logic [7:0] PROD_SRC [NUM_PROD] = '{
		{4'd10, 4'd15}, {4'd14, 4'd11}, {4'd6, 4'd15}, {4'd14, 4'd7},
		{4'd6, 4'd11}, {4'd10, 4'd7}, {4'd2, 4'd15}, {4'd14, 4'd3},
		{4'd2, 4'd11}, {4'd10, 4'd3}, {4'd2, 4'd7}, {4'd6, 4'd3},
		{4'd8, 4'd13}, {4'd12, 4'd9}, {4'd4, 4'd13}, {4'd12, 4'd5},
		{4'd4, 4'd9}, {4'd8, 4'd5}, {4'd0, 4'd13}, {4'd12, 4'd1},
		{4'd0, 4'd9}, {4'd8, 4'd1}, {4'd0, 4'd5}, {4'd4, 4'd1}
	};

	// product index and store index; first three added, last three subtracted
	localparam logic [8:0] COF_SRC [16][NUM_TERMS] = '{
		'{{5'd0, 4'd5}, {5'd3, 4'd9}, {5'd4, 4'd13}, {5'd1, 4'd5}, {5'd2, 4'd9}, {5'd5, 4'd13}},
		'{{5'd1, 4'd1}, {5'd6, 4'd9}, {5'd9, 4'd13}, {5'd0, 4'd1}, {5'd7, 4'd9}, {5'd8, 4'd13}},
		'{{5'd2, 4'd1}, {5'd7, 4'd5}, {5'd10, 4'd13}, {5'd3, 4'd1}, {5'd6, 4'd5}, {5'd11, 4'd13}},
		'{{5'd5, 4'd1}, {5'd8, 4'd5}, {5'd11, 4'd9}, {5'd4, 4'd1}, {5'd9, 4'd5}, {5'd10, 4'd9}},
		'{{5'd1, 4'd4}, {5'd2, 4'd8}, {5'd5, 4'd12}, {5'd0, 4'd4}, {5'd3, 4'd8}, {5'd4, 4'd12}},
		'{{5'd0, 4'd0}, {5'd7, 4'd8}, {5'd8, 4'd12}, {5'd1, 4'd0}, {5'd6, 4'd8}, {5'd9, 4'd12}},
		'{{5'd3, 4'd0}, {5'd6, 4'd4}, {5'd11, 4'd12}, {5'd2, 4'd0}, {5'd7, 4'd4}, {5'd10, 4'd12}},
		'{{5'd4, 4'd0}, {5'd9, 4'd4}, {5'd10, 4'd8}, {5'd5, 4'd0}, {5'd8, 4'd4}, {5'd11, 4'd8}},
		'{{5'd12, 4'd7}, {5'd15, 4'd11}, {5'd16, 4'd15}, {5'd13, 4'd7}, {5'd14, 4'd11},
			{5'd17, 4'd15}},
		'{{5'd13, 4'd3}, {5'd18, 4'd11}, {5'd21, 4'd15}, {5'd12, 4'd3}, {5'd19, 4'd11},
			{5'd20, 4'd15}},
		'{{5'd14, 4'd3}, {5'd19, 4'd7}, {5'd22, 4'd15}, {5'd15, 4'd3}, {5'd18, 4'd7},
			{5'd23, 4'd15}},
		'{{5'd17, 4'd3}, {5'd20, 4'd7}, {5'd23, 4'd11}, {5'd16, 4'd3}, {5'd21, 4'd7},
			{5'd22, 4'd11}},
		'{{5'd14, 4'd10}, {5'd17, 4'd14}, {5'd13, 4'd6}, {5'd16, 4'd14}, {5'd12, 4'd6},
			{5'd15, 4'd10}},
		'{{5'd20, 4'd14}, {5'd12, 4'd2}, {5'd19, 4'd10}, {5'd18, 4'd10}, {5'd21, 4'd14},
			{5'd13, 4'd2}},
		'{{5'd18, 4'd6}, {5'd23, 4'd14}, {5'd15, 4'd2}, {5'd22, 4'd14}, {5'd14, 4'd2},
			{5'd19, 4'd6}},
		'{{5'd22, 4'd10}, {5'd16, 4'd2}, {5'd21, 4'd6}, {5'd20, 4'd6}, {5'd23, 4'd10},
			{5'd17, 4'd2}}
	};

	typedef struct packed {
		logic done;
		logic sat;
	} m4i_stat_t;

endpackage
`default_nettype wire

// File: hdl/matrix4_inverse_top.sv
// 4x4 fixed-point matrix inverse: element store, scratch memory and sequencer
//
// channel  direction  handshake              payload
// in       request    in_valid / in_ready    elem_row elem_col elem_value compute_now
// out      request    out_valid / out_ready  out_row out_col inv_value singular saturated
//                                            last_elem
//
// a final request runs up to 140 serial multiplies on the shared multiplier: 24 products,
// 96 cofactor terms, 4 determinant terms and, for a non-singular matrix, 16 scalings,
// plus one reciprocal in the divider
// each scaled result is computed only after the previous one is taken; a singular matrix
// gives one zero result per cycle while out_ready is high; every result waits for out_ready
// no request is taken until the sixteenth result is taken
// reset clears the sequencer and the multiplier and divider control; the element store holds nothing until written
`timescale 1ns / 1ps
`default_nettype none
module matrix4_inverse_top import m4i_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         elem_row,
	input  wire logic [1:0]         elem_col,
	input  wire logic signed [31:0] elem_value,
	input  wire logic               compute_now,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              out_row,
	output logic [1:0]              out_col,
	output logic signed [31:0]      inv_value,
	output logic                    singular,
	output logic                    saturated,
	output logic                    last_elem
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = DW + 1;
	localparam logic signed [64:0] FX_MAX = (65'sd1 <<< (DW - 1)) - 65'sd1;
	localparam logic signed [64:0] FX_MIN = -FX_MAX - 65'sd1;
	localparam logic signed [64:0] O_MAX  = 65'sd2147483647;
	localparam logic signed [64:0] O_MIN  = -65'sd2147483648;

	typedef enum logic [2:0] {S_IDLE, S_RDA, S_LDA, S_LDB, S_MUL, S_DIV, S_OUT} state_t;
	typedef enum logic [1:0] {PH_PROD, PH_COF, PH_DET, PH_SCALE} phase_t;

	function automatic logic [DW:0] fx_add(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] y);
		logic signed [DW:0] s;
		s = {x[DW-1], x} + {y[DW-1], y};
		if (s[DW] != s[DW-1]) fx_add = {1'b1, s[DW], {(DW-1){~s[DW]}}};
		else fx_add = {1'b0, s[DW-1:0]};
	endfunction

	function automatic logic [DW:0] fx_sub(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] y);
		logic signed [DW:0] s;
		s = {x[DW-1], x} - {y[DW-1], y};
		if (s[DW] != s[DW-1]) fx_sub = {1'b1, s[DW], {(DW-1){~s[DW]}}};
		else fx_sub = {1'b0, s[DW-1:0]};
	endfunction

	state_t state_q;
	phase_t ph_q;
	logic [4:0] idx_q;
	logic [2:0] sub_q;
	logic signed [DW-1:0] a_q, pos_q, neg_q, det_q, rcp_q;
	logic fl_q, csat_q, common_q, sing_q;

	logic          m_we;
	logic [3:0]    m_raddr;
	logic [DW-1:0] m_wdata, m_rdata;
	logic          s_we;
	logic [5:0]    s_waddr, s_raddr;
	logic [SW-1:0] s_wdata, s_rdata;

	logic                 mul_start, div_start;
	logic signed [DW-1:0] mul_a, mul_b, term, div_res;
	m4i_stat_t            mul_stat, div_stat;

	logic [7:0]  psrc;
	logic [8:0]  csrc;
	logic signed [64:0] v65, r65;
	logic signed [DW-1:0] add_lhs;
	logic [DW:0] add_r, sub_r, nv;
	logic        first;
	logic signed [31:0] r32;
	logic        rsat;

	m4i_ram #(.WIDTH(DW), .DEPTH(16)) u_mat (
		.clk, .we(m_we), .waddr({elem_row, elem_col}), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	m4i_ram #(.WIDTH(SW), .DEPTH(64)) u_scr (
		.clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	m4i_mul #(.DW(DW), .FB(FRAC_BITS)) u_mul (
		.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.result(term), .stat(mul_stat)
	);

	m4i_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
		.clk, .arst_n, .start(div_start), .den(nv[DW-1:0]),
		.result(div_res), .stat(div_stat)
	);

	assign in_ready = (state_q == S_IDLE);
	assign m_we     = in_valid && in_ready;

	always_comb begin
		v65 = 65'(elem_value);
		if (v65 > FX_MAX) m_wdata = FX_MAX[DW-1:0];
		else if (v65 < FX_MIN) m_wdata = FX_MIN[DW-1:0];
		else m_wdata = v65[DW-1:0];
	end

	// operand addressing
	always_comb begin
		psrc    = PROD_SRC[idx_q];
		csrc    = COF_SRC[idx_q[3:0]][sub_q];
		m_raddr = psrc[7:4];
		s_raddr = COF_BASE + 6'(idx_q[3:0]);
		unique case (ph_q)
			PH_PROD: m_raddr = (state_q == S_LDA) ? psrc[3:0] : psrc[7:4];
			PH_COF: begin
				m_raddr = csrc[3:0];
				s_raddr = 6'(csrc[8:4]);
			end
			PH_DET: m_raddr = {idx_q[1:0], 2'b00};
			PH_SCALE: m_raddr = psrc[7:4];
			default: m_raddr = psrc[7:4];
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = a_q;
		mul_b     = m_rdata;
		if (state_q == S_LDA) begin
			unique case (ph_q)
				PH_COF: begin
					mul_start = 1'b1;
					mul_a     = s_rdata[DW-1:0];
				end
				PH_DET: begin
					mul_start = 1'b1;
					mul_a     = m_rdata;
					mul_b     = s_rdata[DW-1:0];
				end
				PH_SCALE: begin
					mul_start = 1'b1;
					mul_a     = s_rdata[DW-1:0];
					mul_b     = rcp_q;
				end
				default: mul_start = 1'b0;
			endcase
		end else if (state_q == S_LDB) begin
			mul_start = 1'b1;
		end
	end

	// accumulate and result shaping
	always_comb begin
		add_lhs = (ph_q == PH_DET) ? det_q : ((sub_q < 3'd3) ? pos_q : neg_q);
		first   = (ph_q == PH_DET) ? (idx_q == 5'd0) : (sub_q == 3'd0 || sub_q == 3'd3);
		add_r   = fx_add(add_lhs, term);
		nv      = first ? {1'b0, term} : add_r;
		sub_r   = fx_sub(pos_q, nv[DW-1:0]);
		r65     = 65'(term);
		rsat    = 1'b1;
		if (r65 > O_MAX) r32 = 32'sh7fffffff;
		else if (r65 < O_MIN) r32 = 32'sh80000000;
		else begin
			r32  = r65[31:0];
			rsat = 1'b0;
		end
	end

	assign s_we      = (state_q == S_MUL) && mul_stat.done &&
		(ph_q == PH_PROD || (ph_q == PH_COF && sub_q == 3'd5));
	assign s_waddr   = (ph_q == PH_PROD) ? 6'(idx_q) : COF_BASE + 6'(idx_q[3:0]);
	assign s_wdata   = (ph_q == PH_PROD) ? {mul_stat.sat, term} :
		{csat_q | fl_q | mul_stat.sat | nv[DW] | sub_r[DW], sub_r[DW-1:0]};
	assign div_start = (state_q == S_MUL) && mul_stat.done && ph_q == PH_DET &&
		idx_q == 5'd3 && nv[DW-1:0] != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ph_q      <= PH_PROD;
			idx_q     <= '0;
			sub_q     <= '0;
			sing_q    <= 1'b0;
			common_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && compute_now) begin
						state_q  <= S_RDA;
						ph_q     <= PH_PROD;
						idx_q    <= '0;
						sub_q    <= '0;
						common_q <= 1'b0;
						sing_q   <= 1'b0;
					end
				end
				S_RDA: state_q <= S_LDA;
				S_LDA: begin
					a_q     <= m_rdata;
					fl_q    <= s_rdata[DW];
					state_q <= (ph_q == PH_PROD) ? S_LDB : S_MUL;
				end
				S_LDB: state_q <= S_MUL;
				S_MUL: begin
					if (mul_stat.done) begin
						state_q <= S_RDA;
						unique case (ph_q)
							PH_PROD: begin
								idx_q <= idx_q + 5'd1;
								if (idx_q == 5'(NUM_PROD - 1)) begin
									ph_q  <= PH_COF;
									idx_q <= '0;
								end
							end
							PH_COF: begin
								csat_q <= ((sub_q == 3'd0) ? 1'b0 : csat_q) | fl_q |
									mul_stat.sat | nv[DW];
								if (sub_q < 3'd3) pos_q <= nv[DW-1:0];
								else neg_q <= nv[DW-1:0];
								sub_q <= sub_q + 3'd1;
								if (sub_q == 3'd5) begin
									sub_q <= '0;
									if (idx_q < 5'd4) begin
										common_q <= common_q | s_wdata[DW];
									end
									idx_q <= idx_q + 5'd1;
									if (idx_q == 5'd15) begin
										ph_q  <= PH_DET;
										idx_q <= '0;
									end
								end
							end
							PH_DET: begin
								det_q    <= nv[DW-1:0];
								common_q <= common_q | mul_stat.sat | nv[DW];
								idx_q    <= idx_q + 5'd1;
								if (idx_q == 5'd3) begin
									idx_q <= '0;
									ph_q  <= PH_SCALE;
									if (nv[DW-1:0] == '0) begin
										sing_q    <= 1'b1;
										state_q   <= S_OUT;
										out_valid <= 1'b1;
										out_row   <= 2'd0;
										out_col   <= 2'd0;
										inv_value <= '0;
										singular  <= 1'b1;
										saturated <= 1'b0;
										last_elem <= 1'b0;
									end else begin
										state_q <= S_DIV;
									end
								end
							end
							PH_SCALE: begin
								state_q   <= S_OUT;
								out_valid <= 1'b1;
								out_row   <= idx_q[3:2];
								out_col   <= idx_q[1:0];
								inv_value <= r32;
								singular  <= 1'b0;
								saturated <= fl_q | common_q | mul_stat.sat | rsat;
								last_elem <= (idx_q == 5'd15);
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						rcp_q    <= div_res;
						common_q <= common_q | div_stat.sat;
						state_q  <= S_RDA;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (idx_q == 5'd15) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 5'd1;
							if (sing_q) begin
								out_valid <= 1'b1;
								out_row   <= 2'(5'(idx_q + 5'd1) >> 2);
								out_col   <= 2'(idx_q + 5'd1);
								last_elem <= (idx_q == 5'd14);
							end else begin
								state_q <= S_RDA;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> inv_value == 32'sd0 && !saturated)
		else $error("singular result not zero");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while result pending");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_elem |=> in_ready)
		else $error("not idle after last result");
	a_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |-> state_q == S_LDA || state_q == S_LDB)
		else $error("multiplier started out of sequence");
`endif

endmodule
`default_nettype wire

// File: hdl/m4i_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module m4i_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/m4i_mul.sv
// serial shift-add fixed-point multiplier with rounding and saturation
`timescale 1ns / 1ps
`default_nettype none
module m4i_mul import m4i_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] a,
	input  wire logic signed [DW-1:0] b,
	output logic signed      [DW-1:0] result,
	output m4i_stat_t                 stat
);

	localparam int PW = 2 * DW;
	localparam int CW = $clog2(DW);

	logic          busy_q, fin_q, done_q, sat_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] acc_q, mc_q;
	logic [DW-1:0] mp_q;
	logic signed [DW-1:0] res_q;

	logic [DW-1:0] ua, ub, lim, mag;
	logic [PW:0]   rnd, quo;
	logic          ovf;

	assign ua = a[DW-1] ? DW'(-a) : DW'(a);
	assign ub = b[DW-1] ? DW'(-b) : DW'(b);

	always_comb begin
		rnd = {1'b0, acc_q} + ((PW+1)'(1) << (FB - 1));
		quo = rnd >> FB;
		lim = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		ovf = quo > (PW+1)'(lim);
		mag = ovf ? lim : quo[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= a[DW-1] ^ b[DW-1];
				acc_q  <= '0;
				mc_q   <= PW'(ua);
				mp_q   <= ub;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (mp_q[0]) begin
					acc_q <= acc_q + mc_q;
				end
				mc_q  <= mc_q << 1;
				mp_q  <= mp_q >> 1;
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				sat_q  <= ovf;
				res_q  <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign result    = res_q;
	assign stat.done = done_q;
	assign stat.sat  = sat_q;

endmodule
`default_nettype wire

// File: hdl/m4i_div.sv
// restoring divider forming the rounded fixed-point reciprocal
`timescale 1ns / 1ps
`default_nettype none
module m4i_div import m4i_pkg::*; #(
	parameter int DW = DATA_WIDTH_DEF,
	parameter int FB = FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [DW-1:0] den,
	output logic signed      [DW-1:0] result,
	output m4i_stat_t                 stat
);

	localparam int NW = ((2 * FB > DW) ? 2 * FB : DW) + 1;
	localparam int CW = $clog2(NW);

	logic          busy_q, fin_q, done_q, sat_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] ud_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] num_q, quo_q;
	logic signed [DW-1:0] res_q;

	logic [DW-1:0] ud, lim, mag;
	logic [DW:0]   trial;
	logic          ge, ovf;

	assign ud = den[DW-1] ? DW'(-den) : DW'(den);

	always_comb begin
		trial = {rem_q, num_q[NW-1]};
		ge    = trial >= {1'b0, ud_q};
		lim   = neg_q ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		ovf   = quo_q > NW'(lim);
		mag   = ovf ? lim : quo_q[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				neg_q  <= den[DW-1];
				ud_q   <= ud;
				rem_q  <= '0;
				quo_q  <= '0;
				num_q  <= (NW'(1) << (2 * FB)) + NW'(ud >> 1);
				cnt_q  <= '0;
			end else if (busy_q) begin
				rem_q <= DW'(ge ? trial - {1'b0, ud_q} : trial);
				quo_q <= {quo_q[NW-2:0], ge};
				num_q <= num_q << 1;
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
				sat_q  <= ovf;
				res_q  <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign result    = res_q;
	assign stat.done = done_q;
	assign stat.sat  = sat_q;

endmodule
`default_nettype wire

// File: tb/tb_matrix4_inverse_top.sv
// self-checking testbench for the 4x4 fixed-point matrix inverse
`timescale 1ns / 1ps
module tb_matrix4_inverse_top import m4i_pkg::*;;

	localparam longint FX_HI = 64'sd2147483647;
	localparam longint FX_LO = -64'sd2147483648;
	localparam int TARGET_ITEMS = 480;
	localparam int STALL_LIMIT = 100000;

	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        go;
	} elem_req_t;

	typedef struct {
		logic [1:0]  row;
		logic [1:0]  col;
		logic [31:0] value;
		logic        sing;
		logic        sat;
		logic        last;
	} inv_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] elem_row = '0;
	logic [1:0] elem_col = '0;
	logic signed [31:0] elem_value = '0;
	logic compute_now = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] out_row;
	logic [1:0] out_col;
	logic signed [31:0] inv_value;
	logic singular;
	logic saturated;
	logic last_elem;

	elem_req_t elem_reqs[$];
	inv_res_t inv_pending[$];
	longint mat_shadow[16];
	int n_items = 0;
	int n_accepted = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	bit timed_out = 1'b0;

	matrix4_inverse_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.elem_row(elem_row), .elem_col(elem_col), .elem_value(elem_value),
		.compute_now(compute_now),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_row(out_row), .out_col(out_col), .inv_value(inv_value),
		.singular(singular), .saturated(saturated), .last_elem(last_elem)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic longint clip(longint v, inout bit s);
		if (v > FX_HI) begin
			s = 1'b1;
			return FX_HI;
		end
		if (v < FX_LO) begin
			s = 1'b1;
			return FX_LO;
		end
		return v;
	endfunction

	function automatic longint fx_mult(longint a, longint b, inout bit s);
		bit neg;
		longint ua, ub, q, lim;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		q = (ua * ub + 64'sd32768) >>> 16;
		lim = neg ? 64'sd2147483648 : FX_HI;
		if (q > lim) begin
			s = 1'b1;
			q = lim;
		end
		return neg ? -q : q;
	endfunction

	function automatic longint fx_recip(longint d, inout bit s);
		longint ud, q, lim;
		ud = (d < 0) ? -d : d;
		q = ((64'sd1 <<< 32) + ud / 2) / ud;
		lim = (d < 0) ? 64'sd2147483648 : FX_HI;
		if (q > lim) begin
			s = 1'b1;
			q = lim;
		end
		return (d < 0) ? -q : q;
	endfunction

	// store the accepted element; on a final request queue the 16 inverse elements
	task automatic predict_inverse(elem_req_t r);
		longint prod[NUM_PROD];
		bit psat[NUM_PROD];
		longint cof[16];
		bit csat[16];
		longint pos, negs, term, det, rcp, v;
		bit common, s, sing;
		int p;
		inv_res_t res;
		mat_shadow[{r.row, r.col}] = longint'($signed(r.value));
		if (!r.go)
			return;
		for (int i = 0; i < NUM_PROD; i++) begin
			psat[i] = 1'b0;
			prod[i] = fx_mult(mat_shadow[PROD_SRC[i][7:4]], mat_shadow[PROD_SRC[i][3:0]],
				psat[i]);
		end
		for (int k = 0; k < 16; k++) begin
			csat[k] = 1'b0;
			pos = 0;
			negs = 0;
			for (int t = 0; t < NUM_TERMS; t++) begin
				p = COF_SRC[k][t][8:4];
				if (psat[p])
					csat[k] = 1'b1;
				term = fx_mult(prod[p], mat_shadow[COF_SRC[k][t][3:0]], csat[k]);
				if (t == 0)
					pos = term;
				else if (t < 3)
					pos = clip(pos + term, csat[k]);
				else if (t == 3)
					negs = term;
				else
					negs = clip(negs + term, csat[k]);
			end
			cof[k] = clip(pos - negs, csat[k]);
		end
		common = csat[0] | csat[1] | csat[2] | csat[3];
		det = fx_mult(mat_shadow[0], cof[0], common);
		for (int j = 1; j < 4; j++)
			det = clip(det + fx_mult(mat_shadow[4 * j], cof[j], common), common);
		sing = (det == 0);
		rcp = sing ? 0 : fx_recip(det, common);
		for (int k = 0; k < 16; k++) begin
			v = 0;
			s = 1'b0;
			if (!sing) begin
				s = csat[k] | common;
				v = clip(fx_mult(cof[k], rcp, s), s);
			end
			res.row = k[3:2];
			res.col = k[1:0];
			res.value = v[31:0];
			res.sing = sing;
			res.sat = s;
			res.last = (k == 15);
			inv_pending.push_back(res);
		end
	endtask

	task automatic add_req(int row, int col, logic [31:0] value, bit go);
		elem_req_t r;
		r.row = row[1:0];
		r.col = col[1:0];
		r.value = value;
		r.go = go;
		elem_reqs.push_back(r);
		n_items++;
	endtask

	function automatic logic [31:0] pick_value(int kind);
		case (kind)
			0: return $urandom_range(524288) - 262144;
			1: return $urandom;
			2: begin
				case ($urandom_range(4))
					0: return 32'h7fffffff;
					1: return 32'h80000000;
					2: return 32'h00000001;
					3: return 32'hffffffff;
					default: return 32'h00000000;
				endcase
			end
			default: return ($urandom_range(2) == 0) ? 32'h0 : $urandom_range(131072) - 65536;
		endcase
	endfunction

	// all 16 elements in shuffled order, the last one starts the inversion
	task automatic add_matrix(int kind, bit ident);
		int ord[16];
		int j, tmp;
		for (int i = 0; i < 16; i++)
			ord[i] = i;
		for (int i = 15; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = ord[i];
			ord[i] = ord[j];
			ord[j] = tmp;
		end
		for (int i = 0; i < 16; i++)
			add_req(ord[i] / 4, ord[i] % 4,
				ident ? ((ord[i] % 5 == 0) ? 32'h10000 : 32'h0) : pick_value(kind), i == 15);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		elem_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				r.row = elem_row;
				r.col = elem_col;
				r.value = elem_value;
				r.go = compute_now;
				predict_inverse(r);
				n_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (elem_reqs.size() > 0 &&
						$urandom_range(99) >= (n_accepted < 160 ? 17 : n_accepted < 320 ? 74 : 0)) begin
					r = elem_reqs.pop_front();
					in_valid <= 1'b1;
					elem_row <= r.row;
					elem_col <= r.col;
					elem_value <= r.value;
					compute_now <= r.go;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		inv_res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (inv_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result row %0d col %0d value %h", out_row, out_col,
							inv_value);
				end else begin
					e = inv_pending.pop_front();
					if (out_row !== e.row || out_col !== e.col || inv_value !== e.value ||
							singular !== e.sing || saturated !== e.sat || last_elem !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %0d %0d %h s%0b t%0b l%0b got %0d %0d %h s%0b t%0b l%0b",
								e.row, e.col, e.value, e.sing, e.sat, e.last, out_row, out_col,
								inv_value, singular, saturated, last_elem);
					end
				end
			end
			if (n_accepted >= 320 && !hold_done) begin
				hold_done <= 1'b1;
				hold_cycles <= 20000;
				out_ready <= 1'b0;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= $urandom_range(99) >= (n_accepted < 160 ? 74 : n_accepted < 320 ? 17 : 0);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT)
				timed_out <= 1'b1;
		end
	end

	initial begin
		int kind, n;
		add_matrix(0, 1'b1);
		add_req(0, 0, 32'h7fffffff, 1'b1);
		add_req(3, 3, 32'h80000000, 1'b1);
		for (int c = 0; c < 4; c++)
			add_req(0, c, 32'h0, c == 3);
		while (n_items < TARGET_ITEMS) begin
			n = $urandom_range(99);
			if (n < 60) begin
				n = $urandom_range(99);
				kind = n < 50 ? 0 : n < 70 ? 1 : n < 85 ? 2 : 3;
				add_matrix(kind, 1'b0);
			end else if (n < 85) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					add_req($urandom_range(3), $urandom_range(3), pick_value($urandom_range(3)),
						i == n - 1);
			end else begin
				n = $urandom_range(2, 6);
				for (int i = 0; i < n; i++)
					add_req($urandom_range(3), $urandom_range(3), pick_value($urandom_range(3)), 1'b0);
			end
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!timed_out && (elem_reqs.size() > 0 || in_valid || inv_pending.size() > 0))
			@(posedge clk);
		if (!timed_out)
			repeat (100) @(posedge clk);
		if (!timed_out && mismatches == 0 && inv_pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
